FILE: rtl/core/acp_pkg.sv
// Shared types and constants for the adaptive checkpoint period core.
// Beat payloads, per-object state entry, fixed-point constants, codes.
// No dependencies.
package acp_pkg;

	// Input beat
	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  obj_index;
		logic [31:0] state_cost;
		logic [31:0] coast_cost;
		logic        rollback_done;
		logic [31:0] current_time;
		logic [31:0] event_number;
		logic [31:0] rollback_time;
		logic [31:0] rollback_event;
	} acp_item_t;

	// Result beat
	typedef struct packed {
		logic [5:0] out_object;
		logic       save_checkpoint;
		logic       recalculated;
		logic [7:0] new_period;
		logic       clear_rollback;
	} acp_result_t;

	// Per-object state, one RAM word
	typedef struct packed {
		logic [7:0]  period;
		logic [7:0]  period_countdown;
		logic [15:0] exec_length;
		logic        step_negative;
		logic [31:0] old_cost;
		logic [31:0] filtered_cost;
	} acp_entry_t;

	// Operation codes
	localparam logic [1:0] OP_TIMED = 2'd0;
	localparam logic [1:0] OP_EVENT = 2'd1;
	localparam logic [1:0] OP_COAST = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Configuration register indexes
	localparam int         CFG_IDX_W   = 1;
	localparam int         CFG_DATA_W  = 16;
	localparam logic [0:0] REG_RECALC  = 1'd0;
	localparam logic [0:0] REG_MAXP    = 1'd1;
	localparam logic [15:0] RECALC_RESET = 16'd100;
	localparam logic [7:0]  MAXP_RESET   = 8'd30;

	// Q16 fixed-point constants: 0.4, 0.6, 1.2, 0.8
	localparam int          KW      = 17;
	localparam int          PROD_W  = 32 + KW;
	localparam logic [KW-1:0] K_OLD   = 17'd26214;
	localparam logic [KW-1:0] K_NEW   = 17'd39322;
	localparam logic [KW-1:0] K_UPPER = 17'd78643;
	localparam logic [KW-1:0] K_LOWER = 17'd52429;
	localparam logic [PROD_W-1:0] ROUND_HALF = 49'd32768;

	// Shared multiplier constant select
	typedef enum logic [1:0] {
		MUL_OLD   = 2'd0,
		MUL_NEW   = 2'd1,
		MUL_UPPER = 2'd2,
		MUL_LOWER = 2'd3
	} acp_mul_sel_t;

endpackage

FILE: rtl/core/acp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/acp_mul.sv
// Shared 32 x 17 constant multiplier with registered product.
// Depends on acp_pkg (select codes and Q16 constants).
module acp_mul import acp_pkg::*; (
	input  logic              clk,
	input  acp_mul_sel_t      sel,
	input  logic [31:0]       a,
	output logic [PROD_W-1:0] prod_q
);

	logic [KW-1:0] k;

	always_comb begin
		case (sel)
			MUL_OLD:   k = K_OLD;
			MUL_NEW:   k = K_NEW;
			MUL_UPPER: k = K_UPPER;
			MUL_LOWER: k = K_LOWER;
			default:   k = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(k);
	end

endmodule

FILE: rtl/core/adaptive_checkpoint_period_core.sv
// Adaptive checkpoint period core: top level.
// Depends on acp_pkg, acp_ram, acp_mul.
//
// One engine serves all simulated objects; each item beat names an object and an
// operation, and exactly one result beat comes back per item, in order. Items are
// handled one at a time: a beat that only counts (no period recompute, coast-forward,
// unused code or object out of range) goes through READ, LOAD and UPDATE before the
// next accept; a beat that recomputes the period also goes through MOLD, MNEW, FILT,
// MUP and MLO, because the single shared 32x17 multiplier runs four products in turn
// (0.4 * filtered, 0.6 * cost, then the 1.2x and 0.8x hysteresis products) ahead of
// the RAM write-back. Per-object state is one RAM word per object, read once per item
// and written once per in-range item. A clearing pass after reset zeroes the RAM one
// object per cycle with item_stall high; configuration writes are taken at any time.
// A finished result sits in an output register, so a new item is taken while the
// previous result still waits on result_stall.
module adaptive_checkpoint_period_core import acp_pkg::*; #(
	parameter int NUM_OBJECTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  acp_item_t             item,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output acp_result_t           result,
	// configuration writes
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	// only 64 ids are addressable; larger counts add no storage
	localparam int DEPTH = (NUM_OBJECTS < 64) ? NUM_OBJECTS : 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = $bits(acp_entry_t);

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b00_0000_0001,
		ST_IDLE   = 10'b00_0000_0010,
		ST_READ   = 10'b00_0000_0100,
		ST_LOAD   = 10'b00_0000_1000,
		ST_MOLD   = 10'b00_0001_0000,
		ST_MNEW   = 10'b00_0010_0000,
		ST_FILT   = 10'b00_0100_0000,
		ST_MUP    = 10'b00_1000_0000,
		ST_MLO    = 10'b01_0000_0000,
		ST_UPDATE = 10'b10_0000_0000
	} acp_state_t;

	acp_state_t state_q, state_nxt;

	// configuration registers
	logic [15:0] recalc_interval_q;
	logic [7:0]  max_period_q;

	// working registers
	acp_item_t   item_q;
	logic [AW-1:0] clr_cnt_q;
	logic        recalc_q;
	logic        match_q;
	logic [31:0] cost_q;
	logic [PROD_W-1:0] acc_q;
	logic [31:0] filt_q;
	logic        up_q;
	logic        res_valid_q;
	acp_result_t res_q;

	// RAM and multiplier hookup
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, obj_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	acp_entry_t    ent, nxt;
	acp_mul_sel_t  mul_sel;
	logic [31:0]   mul_a;
	logic [PROD_W-1:0] prod;

	logic        accept, in_range, upd_fire, do_recalc, lo;
	logic [32:0] cost_sum;
	logic [PROD_W-1:0] filt_sum, old_sh;
	logic signed [9:0] p;
	logic        sn, save, clr;
	acp_result_t res_nxt;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign in_range     = (32'(item_q.obj_index) < NUM_OBJECTS);
	assign obj_addr     = item_q.obj_index[AW-1:0];
	assign ent          = acp_entry_t'(ram_rdata);
	assign upd_fire     = (state_q == ST_UPDATE) && (!res_valid_q || !result_stall);

	//-------------------------------------------------------------------------
	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recalc_interval_q <= RECALC_RESET;
			max_period_q      <= MAXP_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_RECALC: recalc_interval_q <= wr_data;
				REG_MAXP:   max_period_q      <= wr_data[7:0];
				default:    ;
			endcase
		end
	end

	//-------------------------------------------------------------------------
	// state RAM: clearing pass writes zero, update writes the new entry
	assign ram_re    = (state_q == ST_READ);
	assign ram_we    = (state_q == ST_CLEAR) || (upd_fire && in_range);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : obj_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : EW'(nxt);

	acp_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (obj_addr),
		.rdata (ram_rdata)
	);

	//-------------------------------------------------------------------------
	// shared multiplier: operand and constant follow the sequencer
	// (the 0.8x product is held while UPDATE waits on the output register)
	always_comb begin
		mul_sel = MUL_OLD;
		mul_a   = ent.filtered_cost;
		case (state_q)
			ST_MNEW: begin
				mul_sel = MUL_NEW;
				mul_a   = cost_q;
			end
			ST_MUP: begin
				mul_sel = MUL_UPPER;
				mul_a   = filt_q;
			end
			ST_MLO, ST_UPDATE: begin
				mul_sel = MUL_LOWER;
				mul_a   = filt_q;
			end
			default: ;
		endcase
	end

	acp_mul u_mul (
		.clk    (clk),
		.sel    (mul_sel),
		.a      (mul_a),
		.prod_q (prod)
	);

	//-------------------------------------------------------------------------
	// LOAD decisions: recompute needed, saturated cost, rollback match
	assign do_recalc = in_range
		&& ((item_q.operation == OP_TIMED) || (item_q.operation == OP_EVENT))
		&& !(ent.exec_length < recalc_interval_q);
	assign cost_sum  = {1'b0, item_q.state_cost} + {1'b0, item_q.coast_cost};
	assign filt_sum  = acc_q + prod;
	// old_cost * 2^16 against the hysteresis products
	assign old_sh    = {1'b0, ent.old_cost, 16'd0};
	assign lo        = (old_sh < prod);

	//-------------------------------------------------------------------------
	// sequencer
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_cnt_q == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
			ST_IDLE:   if (accept) state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = do_recalc ? ST_MOLD : ST_UPDATE;
			ST_MOLD:   state_nxt = ST_MNEW;
			ST_MNEW:   state_nxt = ST_FILT;
			ST_FILT:   state_nxt = ST_MUP;
			ST_MUP:    state_nxt = ST_MLO;
			ST_MLO:    state_nxt = ST_UPDATE;
			ST_UPDATE: if (upd_fire) state_nxt = ST_IDLE;
			default:   state_nxt = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_LOAD) begin
			recalc_q <= do_recalc;
			match_q  <= (item_q.current_time == item_q.rollback_time)
				&& (item_q.event_number <= item_q.rollback_event);
			cost_q   <= cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];
		end
		if (state_q == ST_MNEW) begin
			acc_q <= prod + ROUND_HALF;
		end
		if (state_q == ST_FILT) begin
			filt_q <= (filt_sum[PROD_W-1:48] != '0) ? 32'hFFFF_FFFF : filt_sum[47:16];
		end
		if (state_q == ST_MLO) begin
			up_q <= (old_sh > prod);
		end
	end

	//-------------------------------------------------------------------------
	// new entry and result, evaluated in UPDATE
	always_comb begin
		nxt  = ent;
		p    = $signed({2'b00, ent.period});
		sn   = ent.step_negative;
		save = 1'b0;
		clr  = 1'b0;

		if (recalc_q) begin
			nxt.filtered_cost = filt_q;
			if (ent.old_cost != 32'd0) begin
				if (up_q) begin
					p = p + (sn ? -10'sd1 : 10'sd1);
					nxt.old_cost = filt_q;
				end else if (lo) begin
					// direction reverses before stepping
					sn = !sn;
					p = p + (sn ? -10'sd1 : 10'sd1);
					nxt.old_cost = filt_q;
				end
				// no coast cost: push the period up
				if (item_q.coast_cost == 32'd0) begin
					sn = 1'b0;
					p = p + 10'sd1;
					nxt.old_cost = filt_q;
				end
			end else begin
				p = p + 10'sd1;
				nxt.old_cost = filt_q;
			end
			if (p < 10'sd0) begin
				nxt.period = 8'd0;
			end else if (p > $signed({2'b00, max_period_q})) begin
				nxt.period = max_period_q;
			end else begin
				nxt.period = p[7:0];
			end
			nxt.step_negative = sn;
			nxt.exec_length   = 16'd1;
		end else if ((item_q.operation == OP_TIMED) || (item_q.operation == OP_EVENT)) begin
			nxt.exec_length = ent.exec_length + 16'd1;
		end

		case (item_q.operation)
			OP_TIMED: begin
				if (ent.period_countdown <= 8'd1) begin
					save = 1'b1;
					nxt.period_countdown = nxt.period;
				end else begin
					nxt.period_countdown = ent.period_countdown - 8'd1;
				end
			end
			OP_EVENT: begin
				if (item_q.rollback_done) begin
					save = match_q;
					clr  = 1'b1;
				end else if (ent.period_countdown == 8'd0) begin
					save = 1'b1;
					nxt.period_countdown = nxt.period;
				end else begin
					nxt.period_countdown = ent.period_countdown - 8'd1;
				end
			end
			OP_COAST: begin
				if (item_q.rollback_done) begin
					save = match_q;
					clr  = 1'b1;
				end
			end
			OP_NONE: ;
			default: ;
		endcase

		res_nxt.out_object = item_q.obj_index;
		if (in_range) begin
			res_nxt.save_checkpoint = save;
			res_nxt.recalculated    = recalc_q;
			res_nxt.new_period      = nxt.period;
			res_nxt.clear_rollback  = clr;
		end else begin
			res_nxt.save_checkpoint = 1'b0;
			res_nxt.recalculated    = 1'b0;
			res_nxt.new_period      = 8'd0;
			res_nxt.clear_rollback  = 1'b0;
		end
	end

	//-------------------------------------------------------------------------
	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (upd_fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			res_q <= res_nxt;
		end
	end

endmodule

FILE: rtl/core/acp_checker.sv
// Port-level checks for the adaptive checkpoint period core, plus bind.
// Depends on acp_pkg and adaptive_checkpoint_period_core.
module acp_checker import acp_pkg::*; #(
	parameter int NUM_OBJECTS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input acp_result_t result
);

	// an accepted item keeps the sequencer busy in the cycle after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken on back-to-back cycles");

	// clearing pass holds off items right after reset
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> item_stall)
		else $error("item port open during clearing pass");

	// unknown objects report nothing but their id
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (32'(result.out_object) >= NUM_OBJECTS) |->
		!result.save_checkpoint && !result.recalculated
		&& (result.new_period == 8'd0) && !result.clear_rollback)
		else $error("out-of-range object produced a non-zero result");

	// a waiting result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

endmodule

bind adaptive_checkpoint_period_core acp_checker #(
	.NUM_OBJECTS (NUM_OBJECTS)
) u_acp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for adaptive_checkpoint_period_core: directed and random item beats,
// each result beat checked against an in-bench model of the period adaptation.
// Depends on acp_pkg and the core RTL.
module testbench;
	import acp_pkg::*;

	localparam int N_OBJ = 64;
	localparam int CYCLE_LIMIT = 500000;

	// Q16 weights of the cost filter and hysteresis bands
	localparam bit [63:0] WEIGHT_OLD = 64'd26214;
	localparam bit [63:0] WEIGHT_NEW = 64'd39322;
	localparam bit [63:0] RISE_BAND = 64'd78643;
	localparam bit [63:0] FALL_BAND = 64'd52429;
	localparam bit [63:0] HALF_LSB = 64'd32768;
	localparam bit [63:0] FULL32 = 64'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	acp_item_t item;
	logic result_valid;
	logic result_stall;
	acp_result_t result;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	adaptive_checkpoint_period_core #(.NUM_OBJECTS(N_OBJ)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// model copy of the registers and per-object state
	bit [15:0] cfg_recalc = 16'd100;
	bit [7:0] cfg_max_period = 8'd30;
	bit [7:0] obj_period [N_OBJ];
	bit [7:0] obj_countdown [N_OBJ];
	bit [15:0] obj_run [N_OBJ];
	bit obj_step_down [N_OBJ];
	bit [31:0] obj_last_cost [N_OBJ];
	bit [31:0] obj_smooth_cost [N_OBJ];

	// random cost level per object, drifts up and down
	bit [31:0] cost_trend [N_OBJ];

	acp_result_t pending_decisions [$];
	acp_result_t want;
	int mismatches;
	int cycle_count;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats pending", cycle_count,
				pending_decisions.size());
			$display("testbench: errors");
			$finish;
		end
	end

	// one line per mismatch, all are counted
	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch, cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
	endtask

	// Count one event for object o; on reaching the interval, refilter the cost
	// and step the period. Returns 1 when the period was recomputed.
	function automatic bit tally_event(input int o, input bit [31:0] sc, input bit [31:0] cc);
		bit [63:0] cost;
		bit [63:0] filt;
		bit [63:0] prev;
		int p;
		if (obj_run[o] < cfg_recalc) begin
			obj_run[o]++;
			return 1'b0;
		end
		cost = {32'b0, sc} + {32'b0, cc};
		if (cost > FULL32)
			cost = FULL32;
		filt = ({32'b0, obj_smooth_cost[o]} * WEIGHT_OLD + cost * WEIGHT_NEW + HALF_LSB) >> 16;
		if (filt > FULL32)
			filt = FULL32;
		obj_smooth_cost[o] = filt[31:0];
		prev = {32'b0, obj_last_cost[o]};
		p = obj_period[o];
		if (prev != 0) begin
			if ((prev << 16) > filt * RISE_BAND) begin
				p += obj_step_down[o] ? -1 : 1;
				obj_last_cost[o] = filt[31:0];
			end else if ((prev << 16) < filt * FALL_BAND) begin
				// cost rose: turn the step around, then take it
				obj_step_down[o] = ~obj_step_down[o];
				p += obj_step_down[o] ? -1 : 1;
				obj_last_cost[o] = filt[31:0];
			end
			// no coast-forward cost: always grow
			if (cc == 0) begin
				obj_step_down[o] = 1'b0;
				p += 1;
				obj_last_cost[o] = filt[31:0];
			end
		end else begin
			p += 1;
			obj_last_cost[o] = filt[31:0];
		end
		if (p < 0)
			p = 0;
		else if (p > int'(cfg_max_period))
			p = cfg_max_period;
		obj_period[o] = p[7:0];
		obj_run[o] = 16'd1;
		return 1'b1;
	endfunction

	// Expected result beat for one accepted item beat; updates the model state.
	function automatic acp_result_t next_decision(input acp_item_t it);
		acp_result_t r;
		int o;
		bit rb_hit;
		o = it.obj_index;
		r = '0;
		r.out_object = it.obj_index;
		rb_hit = (it.current_time == it.rollback_time) &&
			(it.event_number <= it.rollback_event);
		case (it.operation)
			OP_TIMED: begin
				r.recalculated = tally_event(o, it.state_cost, it.coast_cost);
				if (obj_countdown[o] <= 1) begin
					r.save_checkpoint = 1'b1;
					obj_countdown[o] = obj_period[o];
				end else begin
					obj_countdown[o]--;
				end
			end
			OP_EVENT: begin
				r.recalculated = tally_event(o, it.state_cost, it.coast_cost);
				if (it.rollback_done) begin
					// rollback pending: countdown left alone
					r.save_checkpoint = rb_hit;
					r.clear_rollback = 1'b1;
				end else if (obj_countdown[o] == 0) begin
					r.save_checkpoint = 1'b1;
					obj_countdown[o] = obj_period[o];
				end else begin
					obj_countdown[o]--;
				end
			end
			OP_COAST: begin
				if (it.rollback_done) begin
					r.save_checkpoint = rb_hit;
					r.clear_rollback = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.new_period = obj_period[o];
		return r;
	endfunction

	// result side: random stall, compare each accepted beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_decisions.size() == 0) begin
				report_mismatch($sformatf("result beat for object %0d with nothing pending",
					result.out_object));
			end else begin
				want = pending_decisions.pop_front();
				check_field("out_object", 8'(result.out_object), 8'(want.out_object));
				check_field("save_checkpoint", 8'(result.save_checkpoint),
					8'(want.save_checkpoint));
				check_field("recalculated", 8'(result.recalculated), 8'(want.recalculated));
				check_field("new_period", result.new_period, want.new_period);
				check_field("clear_rollback", 8'(result.clear_rollback),
					8'(want.clear_rollback));
			end
		end
		result_stall <= !calm && ($urandom_range(99) < 27);
	end

	// Send one item beat. Valid stays high on return; the caller either sends
	// the next beat or drops valid in the same step.
	task automatic send_item(input acp_item_t it);
		while (!calm && $urandom_range(99) < 27) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_decisions.push_back(next_decision(it));
	endtask

	// drop valid, wait for every result, then a margin past the longest latency
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// only called with the core idle
	task automatic apply_config(input bit [15:0] recalc, input bit [7:0] maxp);
		wr_en <= 1'b1;
		wr_index <= REG_RECALC;
		wr_data <= recalc;
		@(posedge clk);
		wr_index <= REG_MAXP;
		wr_data <= {8'b0, maxp};
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_recalc = recalc;
		cfg_max_period = maxp;
	endtask

	function automatic acp_item_t cost_item(input logic [1:0] op, input int obj,
			input bit [31:0] sc, input bit [31:0] cc);
		acp_item_t it;
		it = '0;
		it.operation = op;
		it.obj_index = obj[5:0];
		it.state_cost = sc;
		it.coast_cost = cc;
		return it;
	endfunction

	function automatic acp_item_t rollback_item(input logic [1:0] op, input int obj,
			input bit [31:0] now, input bit [31:0] evn, input bit [31:0] rbt,
			input bit [31:0] rbe);
		acp_item_t it;
		it = cost_item(op, obj, 32'h0001_0000, 32'h0000_8000);
		it.rollback_done = 1'b1;
		it.current_time = now;
		it.event_number = evn;
		it.rollback_time = rbt;
		it.rollback_event = rbe;
		return it;
	endfunction

	// Random beat; most hit the first span objects so their counts reach the
	// interval, and costs follow a drifting level so both hysteresis bands trip.
	function automatic acp_item_t random_item(input int unsigned span);
		acp_item_t it;
		int unsigned pick;
		int unsigned o;
		bit [63:0] grown;
		it = '0;
		pick = $urandom_range(99);
		if (pick < 40)
			it.operation = OP_TIMED;
		else if (pick < 78)
			it.operation = OP_EVENT;
		else if (pick < 95)
			it.operation = OP_COAST;
		else
			it.operation = OP_NONE;
		o = ($urandom_range(99) < 85) ? $urandom_range(span - 1) : $urandom_range(N_OBJ - 1);
		it.obj_index = o[5:0];
		pick = $urandom_range(99);
		if (pick < 10) begin
			// full range, the sum saturates about half the time
			it.state_cost = $urandom;
			it.coast_cost = $urandom;
		end else begin
			if (pick < 35) begin
				case ($urandom_range(2))
					0: grown = {32'b0, cost_trend[o]} * 3 / 2;
					1: grown = {32'b0, cost_trend[o]} * 2 / 3;
					default: grown = $urandom_range(32'hF_FFFF);
				endcase
				cost_trend[o] = (grown > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : grown[31:0];
			end
			it.state_cost = cost_trend[o] + $urandom_range(255);
			it.coast_cost = ($urandom_range(99) < 8) ? 32'd0 :
				(cost_trend[o] >> 1) + $urandom_range(255);
		end
		it.rollback_done = ($urandom_range(99) < 30);
		it.current_time = $urandom;
		it.rollback_time = $urandom_range(1) ? it.current_time :
			($urandom_range(1) ? it.current_time + $urandom_range(1, 3) : $urandom);
		it.event_number = $urandom;
		case ($urandom_range(3))
			0: it.rollback_event = it.event_number;
			1: it.rollback_event = it.event_number + 1;
			2: it.rollback_event = it.event_number - 1;
			default: it.rollback_event = $urandom;
		endcase
		return it;
	endfunction

	// reset register values: unused code, coast-forward, rollback matches and misses
	task automatic test_decisions_at_reset();
		send_item(cost_item(OP_NONE, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(cost_item(OP_COAST, 5, 32'h0, 32'h0));
		send_item(rollback_item(OP_COAST, 5, 32'd40, 32'd7, 32'd40, 32'd7));
		send_item(rollback_item(OP_COAST, 5, 32'd40, 32'd8, 32'd40, 32'd7));
		send_item(rollback_item(OP_EVENT, 6, 32'd41, 32'd1, 32'd40, 32'd9));
		send_item(cost_item(OP_EVENT, 6, 32'h0, 32'h1));
		send_item(cost_item(OP_TIMED, 7, 32'h0, 32'h0));
		send_item(rollback_item(OP_EVENT, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		wait_idle();
	endtask

	// recompute on every timed or event beat first: saturation, zero costs, both bands, clamps
	task automatic test_period_adaptation();
		apply_config(16'd0, 8'd255);
		send_item(cost_item(OP_TIMED, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(cost_item(OP_TIMED, 1, 32'h0, 32'h0));
		send_item(cost_item(OP_EVENT, 1, 32'hFFFF_FFFF, 32'h1));
		send_item(cost_item(OP_TIMED, 2, 32'h0, 32'h0));
		send_item(cost_item(OP_TIMED, 2, 32'h0, 32'h0));
		send_item(cost_item(OP_TIMED, 3, 32'h0010_0000, 32'h0008_0000));
		send_item(cost_item(OP_TIMED, 3, 32'h0010_0000, 32'h0008_0000));
		send_item(cost_item(OP_EVENT, 3, 32'h0000_1000, 32'h0000_0800));
		send_item(cost_item(OP_TIMED, 3, 32'h4000_0000, 32'h2000_0000));
		wait_idle();
		// period clamped to zero
		apply_config(16'd1, 8'd0);
		send_item(cost_item(OP_TIMED, 1, 32'h0000_4000, 32'h0000_4000));
		send_item(cost_item(OP_EVENT, 1, 32'h0000_4000, 32'h0));
		send_item(cost_item(OP_TIMED, 3, 32'h0, 32'h0));
		wait_idle();
		// longest interval, period capped at one
		apply_config(16'hFFFF, 8'd1);
		send_item(cost_item(OP_TIMED, 4, 32'h0001_0000, 32'h0));
		send_item(rollback_item(OP_EVENT, 4, 32'd3, 32'd0, 32'd3, 32'd0));
		wait_idle();
	endtask

	task automatic test_random_phases();
		bit [15:0] recalc_set [8] = '{0, 1, 2, 3, 7, 100, 65535, 4};
		bit [7:0] maxp_set [8] = '{255, 0, 1, 30, 255, 30, 255, 0};
		bit [7:0] maxp;
		int unsigned span;
		for (int ph = 0; ph < 8; ph++) begin
			maxp = (ph == 7) ? 8'($urandom_range(2, 254)) : maxp_set[ph];
			apply_config(recalc_set[ph], maxp);
			span = (ph % 3 == 0) ? N_OBJ : $urandom_range(2, 8);
			for (int n = 0; n < 175; n++)
				send_item(random_item(span));
			wait_idle();
		end
	endtask

	// no idling on either side: back-to-back beats, results taken without stall
	task automatic test_back_to_back();
		apply_config(16'd2, 8'd30);
		calm = 1'b1;
		for (int n = 0; n < 200; n++)
			send_item(random_item(6));
		wait_idle();
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		calm = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decisions_at_reset();
		test_period_adaptation();
		test_random_phases();
		test_back_to_back();
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
